/* rtl/swhsr_pkg.sv */
// Package with the constants, codes and word types of the humidity sensor reader.
`default_nettype none

package swhsr_pkg;

	// Data bits in one sensor frame: two humidity bytes, two temperature bytes, one checksum.
	localparam int FRAME_BITS = 40;
	localparam int BIT_IDX_W  = 6;
	localparam int TICK_W     = 11;

	// Configuration register indexes.
	localparam logic [2:0] REG_START_LOW    = 3'd0;
	localparam logic [2:0] REG_RELEASE      = 3'd1;
	localparam logic [2:0] REG_BIT_SAMPLE   = 3'd2;
	localparam logic [2:0] REG_EDGE_TIMEOUT = 3'd3;
	localparam logic [2:0] REG_FAN_ON       = 3'd4;
	localparam logic [2:0] REG_FAN_OFF      = 3'd5;
	localparam logic [2:0] REG_HEATER_OFF   = 3'd6;
	localparam logic [2:0] REG_HEATER_ON    = 3'd7;

	// Register reset values.
	localparam logic [10:0]        START_LOW_RST    = 11'd1000;
	localparam logic [7:0]         RELEASE_RST      = 8'd30;
	localparam logic [7:0]         BIT_SAMPLE_RST   = 8'd50;
	localparam logic [7:0]         EDGE_TIMEOUT_RST = 8'd255;
	localparam logic signed [15:0] FAN_ON_RST       = 16'sd420;
	localparam logic signed [15:0] FAN_OFF_RST      = 16'sd400;
	localparam logic signed [15:0] HEATER_OFF_RST   = 16'sd20;
	localparam logic signed [15:0] HEATER_ON_RST    = 16'sd0;

	// Read sequence phases.
	localparam logic [2:0] PH_IDLE         = 3'd0;
	localparam logic [2:0] PH_START_LOW    = 3'd1;
	localparam logic [2:0] PH_RELEASE      = 3'd2;
	localparam logic [2:0] PH_RESP_LOW     = 3'd3;
	localparam logic [2:0] PH_RESP_HIGH    = 3'd4;
	localparam logic [2:0] PH_BIT_END_HIGH = 3'd5;
	localparam logic [2:0] PH_BIT_END_LOW  = 3'd6;
	localparam logic [2:0] PH_BIT_DELAY    = 3'd7;

	// Completion status codes.
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NO_RESPONSE = 2'd1;
	localparam logic [1:0] ST_CHECKSUM    = 2'd2;

	// Magnitude sign bit of the sensor temperature word.
	localparam logic [15:0] TEMP_SIGN = 16'h8000;

	// Result word, lowest field last in the declaration so it lands in bit 0.
	typedef struct packed {
		logic                pad;
		logic                heater_on;
		logic                fan_on;
		logic signed [15:0]  temperature_tenths;
		logic [15:0]         humidity_tenths;
		logic [1:0]          status;
		logic                done_res;
		logic                busy_res;
		logic                drive_low;
	} result_t;

endpackage

`default_nettype wire

/* rtl/single_wire_humidity_sensor_reader.sv */
// Top level of the single-wire humidity and temperature sensor reader.
// Each result word is registered, in the output register or, while the master side stalls,
// in the skid register. Throughput: one input word per cycle while the skid register is
// empty; the two-entry output buffer (output register plus skid register) absorbs a stall.
// Reset: arst_n clears the sequencer to idle, the latched readings and flags to zero,
// and loads the configuration registers with their default timing and thresholds.
`default_nettype none

module single_wire_humidity_sensor_reader
	import swhsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,

	// Input words, one per microsecond tick or start request.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
	input  wire logic        s_tuser,   // [0] action: 0 tick, 1 start a new read

	// Result words, one per input word.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [20:5] humidity_tenths,
	// [36:21] temperature_tenths, [37] fan_on, [38] heater_on, [39] zero
	output logic [39:0]      m_tdata
);

	// Configuration registers.
	logic [10:0]        start_low_q;
	logic [7:0]         release_q;
	logic [7:0]         bit_sample_q;
	logic [7:0]         edge_timeout_q;
	logic signed [15:0] fan_on_above_q;
	logic signed [15:0] fan_off_below_q;
	logic signed [15:0] heater_off_above_q;
	logic signed [15:0] heater_on_below_q;

	// Sequencer state.
	logic [2:0]            phase_q, phase_d;
	logic [TICK_W-1:0]     tick_q, tick_d;
	logic [BIT_IDX_W-1:0]  bit_idx_q, bit_idx_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic [15:0]           hum_q, hum_d;
	logic signed [15:0]    temp_q, temp_d;
	logic                  fan_q, fan_d;
	logic                  heater_q, heater_d;

	// Output buffer.
	logic    out_v_q;
	result_t out_q;
	logic    skid_v_q;
	result_t skid_q;

	logic    accept;
	logic    action;
	logic    lvl;
	result_t res_d;

	assign action   = s_tuser;
	assign lvl      = s_tdata[0];
	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// Configuration writes. Indexes beyond the list do not exist with a three-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q        <= START_LOW_RST;
			release_q          <= RELEASE_RST;
			bit_sample_q       <= BIT_SAMPLE_RST;
			edge_timeout_q     <= EDGE_TIMEOUT_RST;
			fan_on_above_q     <= FAN_ON_RST;
			fan_off_below_q    <= FAN_OFF_RST;
			heater_off_above_q <= HEATER_OFF_RST;
			heater_on_below_q  <= HEATER_ON_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_LOW:    start_low_q        <= cfg_data[10:0];
				REG_RELEASE:      release_q          <= cfg_data[7:0];
				REG_BIT_SAMPLE:   bit_sample_q       <= cfg_data[7:0];
				REG_EDGE_TIMEOUT: edge_timeout_q     <= cfg_data[7:0];
				REG_FAN_ON:       fan_on_above_q     <= cfg_data;
				REG_FAN_OFF:      fan_off_below_q    <= cfg_data;
				REG_HEATER_OFF:   heater_off_above_q <= cfg_data;
				REG_HEATER_ON:    heater_on_below_q  <= cfg_data;
				default:          start_low_q        <= start_low_q;
			endcase
		end
	end

	// Next state for one input word. Every wait counts one tick per word; a count
	// compares the incremented tick counter against its limit, so a zero limit
	// behaves like a limit of one. An edge wait also ends when the line leaves the
	// level being held, and a timeout simply moves on as if the edge had come.
	always_comb begin
		logic [TICK_W-1:0]    tick_inc;
		logic                 edge_hit;
		logic [BIT_IDX_W-1:0] idx_inc;
		logic [7:0]           b0, b1, b2, b3, b4;
		logic [7:0]           sum;
		logic [15:0]          raw;
		logic signed [15:0]   t;
		logic                 done;
		logic [1:0]           status;

		tick_inc = tick_q + 1'b1;
		edge_hit = (tick_inc >= {3'b000, edge_timeout_q});
		idx_inc  = bit_idx_q + 1'b1;
		frame_d  = frame_q;
		b0 = frame_d[39:32];
		b1 = frame_d[31:24];
		b2 = frame_d[23:16];
		b3 = frame_d[15:8];
		b4 = frame_d[7:0];
		sum = 8'd0;
		raw = 16'd0;
		t   = 16'sd0;

		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_idx_d = bit_idx_q;
		hum_d     = hum_q;
		temp_d    = temp_q;
		fan_d     = fan_q;
		heater_d  = heater_q;
		done      = 1'b0;
		status    = ST_OK;

		if (action) begin
			// A start request abandons whatever is running.
			phase_d   = PH_START_LOW;
			tick_d    = '0;
			bit_idx_d = '0;
			frame_d   = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_START_LOW: begin
					tick_d = tick_inc;
					if (tick_inc >= start_low_q) begin
						phase_d = PH_RELEASE;
						tick_d  = '0;
					end
				end
				PH_RELEASE: begin
					tick_d = tick_inc;
					if (tick_inc >= {3'b000, release_q}) begin
						tick_d = '0;
						if (!lvl) begin
							phase_d = PH_RESP_LOW;
						end else begin
							// Sensor did not pull the line low: no response.
							phase_d = PH_IDLE;
							done    = 1'b1;
							status  = ST_NO_RESPONSE;
						end
					end
				end
				PH_RESP_LOW: begin
					if (lvl) begin
						phase_d = PH_RESP_HIGH;
						tick_d  = '0;
					end else begin
						tick_d = tick_inc;
						if (edge_hit) begin
							phase_d = PH_RESP_HIGH;
							tick_d  = '0;
						end
					end
				end
				PH_RESP_HIGH, PH_BIT_END_HIGH: begin
					if (!lvl || edge_hit) begin
						phase_d = (phase_q == PH_RESP_HIGH) ? PH_BIT_END_HIGH : PH_BIT_END_LOW;
						tick_d  = '0;
					end else begin
						tick_d = tick_inc;
					end
				end
				PH_BIT_END_LOW: begin
					if (lvl || edge_hit) begin
						phase_d = PH_BIT_DELAY;
						tick_d  = '0;
					end else begin
						tick_d = tick_inc;
					end
				end
				PH_BIT_DELAY: begin
					tick_d = tick_inc;
					if (tick_inc >= {3'b000, bit_sample_q}) begin
						tick_d    = '0;
						frame_d   = {frame_q[FRAME_BITS-2:0], lvl};
						bit_idx_d = idx_inc;
						if (idx_inc >= BIT_IDX_W'(FRAME_BITS)) begin
							phase_d   = PH_IDLE;
							bit_idx_d = '0;
							done      = 1'b1;
							b0  = frame_d[39:32];
							b1  = frame_d[31:24];
							b2  = frame_d[23:16];
							b3  = frame_d[15:8];
							b4  = frame_d[7:0];
							sum = b0 + b1 + b2 + b3;
							if (sum != b4) begin
								status = ST_CHECKSUM;
							end else begin
								hum_d = {b0, b1};
								raw   = {b2, b3};
								// Sign-magnitude to two's complement; negative zero becomes zero.
								if ((raw & TEMP_SIGN) != 16'd0) begin
									t = -$signed({1'b0, raw[14:0]});
								end else begin
									t = $signed(raw);
								end
								temp_d = t;
								if (t > fan_on_above_q)     fan_d    = 1'b1;
								if (t < fan_off_below_q)    fan_d    = 1'b0;
								if (t > heater_off_above_q) heater_d = 1'b0;
								if (t < heater_on_below_q)  heater_d = 1'b1;
							end
						end else begin
							phase_d = PH_BIT_END_HIGH;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			endcase
		end

		res_d.pad                = 1'b0;
		res_d.heater_on          = heater_d;
		res_d.fan_on             = fan_d;
		res_d.temperature_tenths = temp_d;
		res_d.humidity_tenths    = hum_d;
		res_d.status             = status;
		res_d.done_res           = done;
		res_d.busy_res           = (phase_d != PH_IDLE);
		res_d.drive_low          = (phase_d == PH_START_LOW);
	end

	// State advances only on an accepted input word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_idx_q <= '0;
			frame_q   <= '0;
			hum_q     <= '0;
			temp_q    <= '0;
			fan_q     <= 1'b0;
			heater_q  <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_idx_q <= bit_idx_d;
			frame_q   <= frame_d;
			hum_q     <= hum_d;
			temp_q    <= temp_d;
			fan_q     <= fan_d;
			heater_q  <= heater_d;
		end
	end

	// Output register with a skid register behind it. Input is refused only while
	// the skid register holds a word; the skid word always drains first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res_d;
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	// A word waits in the skid register only behind a word in the output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a word while the output register is empty");

	// A start request always opens the drive-low phase.
	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action) |=> (phase_q == PH_START_LOW))
		else $error("start request did not enter the drive-low phase");

	// A nonzero status only comes with a finished sequence, which is no longer busy.
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status != ST_OK) |-> (out_q.done_res && !out_q.busy_res))
		else $error("status reported without a finished sequence");

	// The host drives the line only inside a running sequence.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.drive_low) |-> out_q.busy_res)
		else $error("line driven low while idle");

endmodule

`default_nettype wire

/* tb/single_wire_humidity_sensor_reader_tb.sv */
// Self-checking testbench for the single-wire humidity sensor reader, with a model of the sensor.

module single_wire_humidity_sensor_reader_tb
	import swhsr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// The watchdog gives up after this many cycles in which no word moves on either side.
	localparam int STALL_LIMIT = 2000;

	// How the modeled sensor behaves during one reading.
	localparam int STYLE_CLEAN = 0;   // well-formed timing, sensor data lands on the sample tick
	localparam int STYLE_NOISY = 1;   // line level is random on every tick
	localparam int STYLE_SLOW  = 2;   // levels are held long, so edge waits tend to time out

	// Scoreboard: a cycle-true copy of the read sequencer that predicts one result word per
	// accepted input word, and a queue of those predictions that the output side drains.
	class humidity_scoreboard;
		logic [10:0]        start_low;
		logic [7:0]         release_len;
		logic [7:0]         sample_delay;
		logic [7:0]         edge_limit;
		logic signed [15:0] fan_on_thr;
		logic signed [15:0] fan_off_thr;
		logic signed [15:0] heat_off_thr;
		logic signed [15:0] heat_on_thr;

		logic [2:0]         phase;
		logic [10:0]        ticks;
		logic [5:0]         bit_idx;
		logic [39:0]        frame;
		logic [15:0]        humidity;
		logic signed [15:0] temperature;
		logic               fan;
		logic               heater;

		result_t            expected_q[$];
		int                 errors;

		function new();
			start_low    = START_LOW_RST;
			release_len  = RELEASE_RST;
			sample_delay = BIT_SAMPLE_RST;
			edge_limit   = EDGE_TIMEOUT_RST;
			fan_on_thr   = FAN_ON_RST;
			fan_off_thr  = FAN_OFF_RST;
			heat_off_thr = HEATER_OFF_RST;
			heat_on_thr  = HEATER_ON_RST;
			phase        = PH_IDLE;
			ticks        = '0;
			bit_idx      = '0;
			frame        = '0;
			humidity     = '0;
			temperature  = '0;
			fan          = 1'b0;
			heater       = 1'b0;
			errors       = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] value);
			case (idx)
				REG_START_LOW:    start_low    = value[10:0];
				REG_RELEASE:      release_len  = value[7:0];
				REG_BIT_SAMPLE:   sample_delay = value[7:0];
				REG_EDGE_TIMEOUT: edge_limit   = value[7:0];
				REG_FAN_ON:       fan_on_thr   = value;
				REG_FAN_OFF:      fan_off_thr  = value;
				REG_HEATER_OFF:   heat_off_thr = value;
				REG_HEATER_ON:    heat_on_thr  = value;
				default: ;
			endcase
		endfunction

		// The tick counter wraps at 11 bits; a zero limit ends on the first tick, since ticks >= 0 holds.
		function bit tick_done(logic [10:0] limit);
			ticks = ticks + 11'd1;
			return ticks >= limit;
		endfunction

		// A wait on a held level ends on the opposite level or when the edge timeout runs out.
		function bit edge_wait(logic lvl, logic held);
			if (lvl != held)
				return 1'b1;
			return tick_done({3'b000, edge_limit});
		endfunction

		// Checks the byte sum, then latches the reading and updates the hysteresis flags.
		// The off rule of the fan and the on rule of the heater are applied last, so they win.
		function logic [1:0] close_frame();
			logic [7:0]  sum;
			logic [15:0] raw;
			int          t;
			sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
			if (sum != frame[7:0])
				return ST_CHECKSUM;
			humidity = frame[39:24];
			raw = frame[23:8];
			t = int'(raw & ~TEMP_SIGN);
			if ((raw & TEMP_SIGN) != 16'h0000)
				t = -t;
			temperature = 16'(t);
			if (t > int'(fan_on_thr))
				fan = 1'b1;
			if (t < int'(fan_off_thr))
				fan = 1'b0;
			if (t > int'(heat_off_thr))
				heater = 1'b0;
			if (t < int'(heat_on_thr))
				heater = 1'b1;
			return ST_OK;
		endfunction

		function void note_input(logic start, logic lvl);
			result_t    r;
			logic       done;
			logic [1:0] st;
			done = 1'b0;
			st = ST_OK;
			if (start) begin
				// A start always restarts, abandoning any read in progress.
				phase = PH_START_LOW;
				ticks = '0;
				bit_idx = '0;
				frame = '0;
			end else begin
				case (phase)
					PH_IDLE: ;
					PH_START_LOW: if (tick_done(start_low)) begin
						phase = PH_RELEASE;
						ticks = '0;
					end
					PH_RELEASE: if (tick_done({3'b000, release_len})) begin
						ticks = '0;
						if (!lvl) begin
							phase = PH_RESP_LOW;
						end else begin
							phase = PH_IDLE;
							done = 1'b1;
							st = ST_NO_RESPONSE;
						end
					end
					PH_RESP_LOW: if (edge_wait(lvl, 1'b0)) begin
						phase = PH_RESP_HIGH;
						ticks = '0;
					end
					PH_RESP_HIGH: if (edge_wait(lvl, 1'b1)) begin
						phase = PH_BIT_END_HIGH;
						ticks = '0;
					end
					PH_BIT_END_HIGH: if (edge_wait(lvl, 1'b1)) begin
						phase = PH_BIT_END_LOW;
						ticks = '0;
					end
					PH_BIT_END_LOW: if (edge_wait(lvl, 1'b0)) begin
						phase = PH_BIT_DELAY;
						ticks = '0;
					end
					PH_BIT_DELAY: if (tick_done({3'b000, sample_delay})) begin
						ticks = '0;
						frame = {frame[38:0], lvl};
						bit_idx = bit_idx + 6'd1;
						if (bit_idx >= FRAME_BITS) begin
							st = close_frame();
							done = 1'b1;
							phase = PH_IDLE;
							bit_idx = '0;
						end else begin
							phase = PH_BIT_END_HIGH;
						end
					end
					default: begin
						phase = PH_IDLE;
						ticks = '0;
					end
				endcase
			end
			r = '0;
			r.drive_low = (phase == PH_START_LOW);
			r.busy_res = (phase != PH_IDLE);
			r.done_res = done;
			r.status = st;
			r.humidity_tenths = humidity;
			r.temperature_tenths = temperature;
			r.fan_on = fan;
			r.heater_on = heater;
			expected_q.push_back(r);
		endfunction

		function string describe(result_t r);
			return $sformatf({"drive_low=%0b busy=%0b done=%0b status=%0d humidity=%0d ",
				"temperature=%0d fan=%0b heater=%0b pad=%0b"}, r.drive_low, r.busy_res,
				r.done_res, r.status, r.humidity_tenths, r.temperature_tenths, r.fan_on,
				r.heater_on, r.pad);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result word with none expected: %s", describe(got));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result word mismatch\n  expected %s\n  actual   %s",
						describe(want), describe(got));
			end
		endfunction
	endclass

	// One planned sensor reading: the 40 frame bits and whether the sensor stays silent.
	typedef struct packed {
		logic        silent;
		logic [39:0] bits;
	} reading_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = REG_START_LOW;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;

	humidity_scoreboard sb;

	// Percent of cycles in which the sender holds back a word and the receiver stalls.
	int src_idle_pct = 0;
	int snk_stall_pct = 0;

	// Words given verbatim before the sensor model takes over, as {action, line_level}.
	logic [1:0] directed_q[$];
	// Readings the sensor model plays before it falls back to random ones.
	reading_t   reading_plan[$];
	reading_t   cur_reading = '0;
	int         cur_style = STYLE_CLEAN;

	single_wire_humidity_sensor_reader i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver backpressure, redrawn every cycle.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Every result word taken by the receiver is checked against the oldest prediction.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(result_t'(m_tdata));
	end

	// Watchdog: the run is declared failed when nothing moves for too long.
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stalled = 0;
			else
				stalled++;
		end
		$display("** single_wire_humidity_sensor_reader: FAILED **");
		$finish;
	end

	// Frame as the sensor sends it: humidity, temperature, then the byte sum,
	// optionally spoiled by a nonzero offset so the checksum fails.
	function automatic logic [39:0] frame_of(logic [15:0] hum, logic [15:0] raw, bit corrupt);
		logic [7:0] sum;
		sum = hum[15:8] + hum[7:0] + raw[15:8] + raw[7:0];
		if (corrupt)
			sum = sum + 8'(1 + $urandom_range(254));
		return {hum, raw, sum};
	endfunction

	// The sensor reports temperature as sign and magnitude.
	function automatic logic [15:0] sign_mag(int v);
		return (v < 0) ? (TEMP_SIGN | 16'(-v)) : 16'(v);
	endfunction

	function automatic void start_reading();
		int          pick;
		logic [15:0] raw;
		if (reading_plan.size() != 0) begin
			cur_reading = reading_plan.pop_front();
			cur_style = STYLE_CLEAN;
		end else begin
			pick = $urandom_range(99);
			cur_style = (pick < 75) ? STYLE_CLEAN : (pick < 90) ? STYLE_NOISY : STYLE_SLOW;
			// Half the temperatures sit near the thresholds, the rest use the whole word.
			if ($urandom_range(1))
				raw = sign_mag(int'($urandom_range(1200)) - 600);
			else
				raw = 16'($urandom);
			cur_reading.bits = frame_of(16'($urandom), raw, $urandom_range(99) < 12);
			cur_reading.silent = ($urandom_range(99) < 8);
		end
	endfunction

	// Sensor model: picks the next word from the predicted sequencer state, so that most
	// readings follow the protocol and put the planned bit on the line at each sample tick.
	function automatic void choose_word(output logic act, output logic lvl);
		int hold_pct;
		act = 1'b0;
		lvl = $urandom_range(1);
		if (directed_q.size() != 0) begin
			{act, lvl} = directed_q.pop_front();
			return;
		end
		// Mostly start a read when idle; very rarely abandon a read in progress.
		if ((sb.phase == PH_IDLE) ? ($urandom_range(99) < 60) : ($urandom_range(1999) == 0)) begin
			start_reading();
			act = 1'b1;
			return;
		end
		if (cur_style == STYLE_NOISY)
			return;
		hold_pct = (cur_style == STYLE_SLOW) ? 97 : 40;
		case (sb.phase)
			PH_RELEASE: if (sb.ticks + 11'd1 >= {3'b000, sb.release_len})
				lvl = cur_reading.silent;
			PH_RESP_LOW, PH_BIT_END_LOW: lvl = ($urandom_range(99) >= hold_pct);
			PH_RESP_HIGH, PH_BIT_END_HIGH: lvl = ($urandom_range(99) < hold_pct);
			PH_BIT_DELAY: begin
				if (sb.ticks + 11'd1 >= {3'b000, sb.sample_delay})
					lvl = cur_reading.bits[39 - sb.bit_idx];
				else
					lvl = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Sends a number of input words. A word is noted by the scoreboard at the edge that takes
	// it, and the next word is chosen only afterwards, from the updated prediction.
	task automatic send_words(int count);
		int   taken;
		logic act;
		logic lvl;
		taken = 0;
		while (taken < count) begin
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				sb.note_input(s_tuser, s_tdata[0]);
				taken++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (taken < count && $urandom_range(99) >= src_idle_pct) begin
					choose_word(act, lvl);
					s_tvalid <= 1'b1;
					s_tuser <= act;
					s_tdata <= {7'b0000000, lvl};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	endtask

	// Waits until every predicted word has come back, then lets the pipeline settle.
	task automatic drain();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(idx, value);
	endtask

	task automatic apply_setting(logic [15:0] low_len, logic [15:0] rel_len,
			logic [15:0] smp_len, logic [15:0] tmo_len, logic [15:0] fan_on_val,
			logic [15:0] fan_off_val, logic [15:0] heat_off_val, logic [15:0] heat_on_val);
		write_reg(REG_START_LOW, low_len);
		write_reg(REG_RELEASE, rel_len);
		write_reg(REG_BIT_SAMPLE, smp_len);
		write_reg(REG_EDGE_TIMEOUT, tmo_len);
		write_reg(REG_FAN_ON, fan_on_val);
		write_reg(REG_FAN_OFF, fan_off_val);
		write_reg(REG_HEATER_OFF, heat_off_val);
		write_reg(REG_HEATER_ON, heat_on_val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset timing: ticks while idle on both line levels, a start whose line level is
		// ignored, and a second start that abandons the read already running.
		directed_q = '{2'b00, 2'b01, 2'b11, 2'b00, 2'b01, 2'b10, 2'b00, 2'b01};
		send_words(directed_q.size());
		drain();

		// Short timing. A read where the line is still high at the response check ends
		// without response; then planned readings cover the field extremes with a fan
		// switch-on, a negative zero, a heater switch-on and a checksum failure.
		apply_setting(16'd2, 16'd2, 16'd1, 16'd8, 16'd420, 16'd400, 16'd20, 16'd0);
		directed_q = '{2'b10, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00};
		reading_plan.push_back({1'b0, frame_of(16'hFFFF, 16'h7FFF, 1'b0)});
		reading_plan.push_back({1'b0, frame_of(16'h0000, 16'h8000, 1'b0)});
		reading_plan.push_back({1'b0, frame_of(16'h8001, 16'hFFFF, 1'b0)});
		reading_plan.push_back({1'b0, frame_of(16'd300, sign_mag(215), 1'b1)});
		send_words(760);
		drain();
		reading_plan.delete();

		// Zero timing registers behave as one; each threshold pair overlaps, so a
		// temperature between them hits both rules of a pair. Sender idles often.
		apply_setting(16'd0, 16'd0, 16'd0, 16'd0, -16'sd100, 16'sd100, -16'sd100, 16'sd100);
		src_idle_pct = 77;
		send_words(80);
		drain();

		// Minimum timing, so edge waits time out constantly; thresholds at the ends of
		// the 16-bit range. Receiver stalls often.
		apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		src_idle_pct = 0;
		snk_stall_pct = 77;
		send_words(80);
		drain();

		// Small timing with junk in the unused start-low bits, random thresholds near
		// zero; both sides idle now and then.
		apply_setting({5'($urandom), 11'd3}, 16'd4, 16'd3, 16'd255,
			16'(int'($urandom_range(1200)) - 600), 16'(int'($urandom_range(1200)) - 600),
			16'(int'($urandom_range(1200)) - 600), 16'(int'($urandom_range(1200)) - 600));
		src_idle_pct = 20;
		snk_stall_pct = 20;
		send_words(80);
		drain();

		// Longest sample delay and edge timeout behind a short start and release, so that a bit
		// can be sampled at the longest delay.
		apply_setting(16'd8, 16'd8, 16'd255, 16'd255, 16'h8001, 16'h8001, 16'h7FFF,
			16'h8001);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_words(300);
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("** single_wire_humidity_sensor_reader: PASSED **");
		else
			$display("** single_wire_humidity_sensor_reader: FAILED **");
		$finish;
	end

endmodule
